[design/ptfl_pkg.sv]
`timescale 1ns / 1ps
package ptfl_pkg;

    localparam int VA_BITS     = 22;
    localparam int OFFSET_BITS = 12;
    localparam int PAGE_BITS   = 10;
    localparam int NUM_PAGES   = 1 << PAGE_BITS;
    localparam int MAX_FRAMES  = 64;
    localparam int FRAME_BITS  = $clog2(MAX_FRAMES);
    localparam int QCNT_BITS   = FRAME_BITS + 1;
    localparam int PT_WIDTH    = FRAME_BITS + 1;
    localparam int PA_BITS     = FRAME_BITS + OFFSET_BITS;
    localparam int CFG_BITS    = VA_BITS + 1;

    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t CFG_NUM_FRAMES = 2'd0;
    localparam cfg_index_t CFG_POLICY     = 2'd1;
    localparam cfg_index_t CFG_RANGE_LOW  = 2'd2;
    localparam cfg_index_t CFG_RANGE_HIGH = 2'd3;

    typedef logic [1:0] status_t;
    localparam status_t ST_HIT     = 2'd0;
    localparam status_t ST_FREE    = 2'd1;
    localparam status_t ST_EVICT   = 2'd2;
    localparam status_t ST_INVALID = 2'd3;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_DEC,
        S_EVR,
        S_EVD,
        S_EVF,
        S_EVW,
        S_SRD,
        S_SCMP,
        S_MCHK,
        S_MWR,
        S_DONE
    } state_t;

endpackage

[design/paged_translation_fifo_lru.sv]
`timescale 1ns / 1ps
// invalid words go straight to done; hits and free-frame faults read, then decode the page entry
// evictions then read queue head and victim entry; lru hits search and shift the queue words
// throughput: one word at a time, busy stays high until the result strobe
// reset: after rst_n rises a clearing pass sweeps all 1024 page table entries, busy high
// the result is shown for one cycle on done; the receiver cannot stall
module paged_translation_fifo_lru
    import ptfl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [VA_BITS-1:0]    virt_addr,
    output logic                  busy,
    output logic                  done,
    output logic [PA_BITS-1:0]    real_addr,
    output logic [1:0]            access_status,
    output logic [PAGE_BITS-1:0]  victim_page,
    output logic [31:0]           faults_so_far,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_BITS-1:0]   cfg_data
);

    state_t state_reg, state_next;

    logic [QCNT_BITS-1:0]  nf_reg;
    logic                  lru_reg;
    logic [VA_BITS-1:0]    low_reg;
    logic [CFG_BITS-1:0]   high_reg;

    logic [VA_BITS-1:0]    addr_reg;
    logic [FRAME_BITS-1:0] frame_reg;
    status_t               status_reg;
    logic [PAGE_BITS-1:0]  victim_reg;
    logic [31:0]           fault_reg;
    logic [QCNT_BITS-1:0]  nff_reg;
    logic [QCNT_BITS-1:0]  qlen_reg;
    logic [FRAME_BITS-1:0] head_reg;
    logic [QCNT_BITS-1:0]  idx_reg;
    logic [PAGE_BITS-1:0]  clr_reg;

    logic                  pt_we, pt_re;
    logic [PAGE_BITS-1:0]  pt_waddr, pt_raddr;
    logic [PT_WIDTH-1:0]   pt_wdata, pt_rdata;
    logic                  q_we, q_re;
    logic [FRAME_BITS-1:0] q_waddr, q_raddr;
    logic [PAGE_BITS-1:0]  q_wdata, q_rdata;

    logic [PAGE_BITS-1:0]  page;
    logic [QCNT_BITS-1:0]  limit;
    logic                  accept;
    logic                  addr_bad;
    logic                  take_free;
    logic [FRAME_BITS-1:0] free_frame;
    logic [QCNT_BITS-1:0]  idx_inc;

    assign page      = addr_reg[VA_BITS-1:OFFSET_BITS];
    assign accept    = start && (state_reg == S_IDLE);
    assign addr_bad  = (virt_addr < low_reg) || ({1'b0, virt_addr} >= high_reg);
    assign idx_inc   = idx_reg + QCNT_BITS'(1);

    always_comb
    begin
        if (nf_reg == '0)
            limit = QCNT_BITS'(1);
        else if (nf_reg > QCNT_BITS'(MAX_FRAMES))
            limit = QCNT_BITS'(MAX_FRAMES);
        else
            limit = nf_reg;
    end

    assign take_free  = (nff_reg < limit) || (qlen_reg == '0);
    assign free_frame = (nff_reg < QCNT_BITS'(MAX_FRAMES)) ? nff_reg[FRAME_BITS-1:0] : '0;

    ptfl_ram #(.DEPTH(NUM_PAGES), .WIDTH(PT_WIDTH)) u_page_table (
        .clk   (clk),
        .we    (pt_we),
        .waddr (pt_waddr),
        .wdata (pt_wdata),
        .re    (pt_re),
        .raddr (pt_raddr),
        .rdata (pt_rdata)
    );

    ptfl_ram #(.DEPTH(MAX_FRAMES), .WIDTH(PAGE_BITS)) u_queue (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .re    (q_re),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: if (clr_reg == PAGE_BITS'(NUM_PAGES - 1)) state_next = S_IDLE;
            S_IDLE:  if (start) state_next = addr_bad ? S_DONE : S_RD;
            S_RD:    state_next = S_DEC;
            S_DEC:
            begin
                if (pt_rdata[FRAME_BITS])
                    state_next = (lru_reg && qlen_reg != '0) ? S_SRD : S_DONE;
                else
                    state_next = take_free ? S_DONE : S_EVR;
            end
            S_EVR:   state_next = S_EVD;
            S_EVD:   state_next = S_EVF;
            S_EVF:   state_next = S_EVW;
            S_EVW:   state_next = S_DONE;
            S_SRD:   state_next = S_SCMP;
            S_SCMP:
            begin
                if (q_rdata == page)
                    state_next = S_MCHK;
                else if (idx_inc == qlen_reg)
                    state_next = S_DONE;
                else
                    state_next = S_SRD;
            end
            S_MCHK:  state_next = (idx_inc < qlen_reg) ? S_MWR : S_DONE;
            S_MWR:   state_next = S_MCHK;
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // memory controls
    always_comb
    begin
        pt_we    = 1'b0;
        pt_waddr = page;
        pt_wdata = {1'b1, frame_reg};
        pt_re    = 1'b0;
        pt_raddr = page;
        q_we     = 1'b0;
        q_waddr  = head_reg + qlen_reg[FRAME_BITS-1:0];
        q_wdata  = page;
        q_re     = 1'b0;
        q_raddr  = head_reg + idx_reg[FRAME_BITS-1:0];
        case (state_reg)
            S_CLEAR:
            begin
                pt_we    = 1'b1;
                pt_waddr = clr_reg;
                pt_wdata = '0;
            end
            S_RD:    pt_re = 1'b1;
            S_DEC:
            begin
                if (!pt_rdata[FRAME_BITS] && take_free)
                begin
                    pt_we    = 1'b1;
                    pt_wdata = {1'b1, free_frame};
                    q_we     = (qlen_reg < QCNT_BITS'(MAX_FRAMES));
                end
            end
            S_EVR:
            begin
                q_re    = 1'b1;
                q_raddr = head_reg;
            end
            S_EVD:
            begin
                pt_re    = 1'b1;
                pt_raddr = q_rdata;
            end
            S_EVF:
            begin
                // victim keeps its frame bits, only the present bit drops
                pt_we    = 1'b1;
                pt_waddr = victim_reg;
                pt_wdata = {1'b0, pt_rdata[FRAME_BITS-1:0]};
            end
            S_EVW:
            begin
                pt_we = 1'b1;
                q_we  = 1'b1;
            end
            S_SRD:   q_re = 1'b1;
            S_MCHK:
            begin
                if (idx_inc < qlen_reg)
                begin
                    q_re    = 1'b1;
                    q_raddr = head_reg + idx_inc[FRAME_BITS-1:0];
                end
                else
                begin
                    q_we    = 1'b1;
                    q_waddr = head_reg + idx_reg[FRAME_BITS-1:0];
                end
            end
            S_MWR:
            begin
                q_we    = 1'b1;
                q_waddr = head_reg + idx_reg[FRAME_BITS-1:0];
                q_wdata = q_rdata;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            nf_reg     <= QCNT_BITS'(MAX_FRAMES);
            lru_reg    <= 1'b0;
            low_reg    <= '0;
            high_reg   <= CFG_BITS'(1 << VA_BITS);
            fault_reg  <= '0;
            nff_reg    <= '0;
            qlen_reg   <= '0;
            head_reg   <= '0;
            idx_reg    <= '0;
            clr_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_NUM_FRAMES: nf_reg   <= cfg_data[QCNT_BITS-1:0];
                    CFG_POLICY:     lru_reg  <= cfg_data[0];
                    CFG_RANGE_LOW:  low_reg  <= cfg_data[VA_BITS-1:0];
                    CFG_RANGE_HIGH: high_reg <= cfg_data;
                    default: ;
                endcase
            end
            case (state_reg)
                S_CLEAR: clr_reg <= clr_reg + PAGE_BITS'(1);
                S_DEC:
                begin
                    if (pt_rdata[FRAME_BITS])
                        idx_reg <= '0;
                    else if (take_free)
                    begin
                        if (nff_reg < QCNT_BITS'(MAX_FRAMES))
                            nff_reg <= nff_reg + QCNT_BITS'(1);
                        if (qlen_reg < QCNT_BITS'(MAX_FRAMES))
                            qlen_reg <= qlen_reg + QCNT_BITS'(1);
                        fault_reg <= fault_reg + 32'd1;
                    end
                end
                S_EVW:
                begin
                    head_reg  <= head_reg + FRAME_BITS'(1);
                    fault_reg <= fault_reg + 32'd1;
                end
                S_SCMP:  if (q_rdata != page) idx_reg <= idx_inc;
                S_MWR:   idx_reg <= idx_inc;
                default: ;
            endcase
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    addr_reg   <= virt_addr;
                    victim_reg <= '0;
                    frame_reg  <= '0;
                    status_reg <= ST_INVALID;
                end
            end
            S_DEC:
            begin
                if (pt_rdata[FRAME_BITS])
                begin
                    status_reg <= ST_HIT;
                    frame_reg  <= pt_rdata[FRAME_BITS-1:0];
                end
                else if (take_free)
                begin
                    status_reg <= ST_FREE;
                    frame_reg  <= free_frame;
                end
                else
                begin
                    status_reg <= ST_EVICT;
                end
            end
            S_EVD:   victim_reg <= q_rdata;
            S_EVF:   frame_reg  <= pt_rdata[FRAME_BITS-1:0];
            default: ;
        endcase
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = (state_reg == S_DONE);
    assign cfg_ready     = 1'b1;
    assign real_addr     = (status_reg == ST_INVALID) ? '0
                         : {frame_reg, addr_reg[OFFSET_BITS-1:0]};
    assign access_status = status_reg;
    assign victim_page   = victim_reg;
    assign faults_so_far = fault_reg;

`ifndef ASSERT_OFF
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe outside a busy period");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted word did not raise busy");

    a_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && access_status != ST_EVICT) |-> (victim_page == '0))
        else $error("victim page set without eviction");

    a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (access_status == ST_HIT || access_status == ST_INVALID))
            |-> (faults_so_far == $past(faults_so_far)))
        else $error("fault count moved on a hit or invalid word");
`endif

endmodule

[design/ptfl_ram.sv]
`timescale 1ns / 1ps
module ptfl_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
